// ===== src/gaussian_kernel_field_query_assert.svh =====
// Assertion macros shared by the field query block.
`ifndef GAUSSIAN_KERNEL_FIELD_QUERY_ASSERT_SVH
`define GAUSSIAN_KERNEL_FIELD_QUERY_ASSERT_SVH
`ifndef SYNTHESIS
`define GKFQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gkfq assertion failed");
`define GKFQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gkfq assertion failed");
`else
`define GKFQ_ASSERT_IMP(label, ante, cons)
`define GKFQ_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== src/gkfq_pkg.sv =====
// Package with types, constants and the exponential table of the field query block.
`default_nettype none
package gkfq_pkg;

    localparam int GKFQ_MAX_ENTRIES = 256;
    localparam int SUM_W = 23;
    localparam int TERM_W = 22;
    localparam logic [TERM_W-1:0] TERM_CAP = 22'h20_0000;
    localparam logic [63:0] EPS_Q32 = 64'd4295;
    localparam logic [63:0] ONE_Q48 = 64'h0001_0000_0000_0000;
    localparam int WEIGHT_FLOOR = 4295;
    localparam int WR_QUO_W = 37;
    localparam int RD_QUO_W = 17;
    localparam logic [63:0] EXP_QUARTER_Q32 = 64'd3344923893;
    localparam logic REG_ACTIVE_ENTRIES = 1'b0;
    localparam logic REG_NO_SIGNAL = 1'b1;

    typedef logic [64:0][32:0] t_exp_tab;

    typedef struct packed {
        logic valid;
        logic last;
    } t_flow;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_SQ,
        ST_W_DEN,
        ST_W_START,
        ST_W_WAIT,
        ST_Q_RUN,
        ST_Q_DRAIN,
        ST_Q_PREP,
        ST_Q_START,
        ST_Q_WAIT,
        ST_Q_SIGN,
        ST_Q_DONE
    } t_state;

    function automatic t_exp_tab build_exp_tab();
        t_exp_tab tab;
        logic [63:0] t;
        tab = '0;
        t = 64'h1_0000_0000;
        tab[0] = t[32:0];
        for (int k = 0; k < 64; k++) begin
            t = (t * EXP_QUARTER_Q32 + 64'h8000_0000) >> 32;
            tab[k + 1] = t[32:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

// ===== src/gkfq_serial_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module gkfq_serial_div
    import gkfq_pkg::*;
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 64,
    parameter int QUO_W = WR_QUO_W
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [NUM_W-1:0]  i_num,
    input  wire [DEN_W-1:0]  i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);
    localparam int CW = (QUO_W > 1) ? $clog2(QUO_W) : 1;

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_lo;
    logic [DEN_W:0]   w_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_sh   = {r_rem, r_lo[QUO_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(i_num >> QUO_W);
            r_lo  <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
            r_lo  <= {r_lo[QUO_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_lo;

endmodule
`default_nettype wire

// ===== src/gkfq_axis_cell.sv =====
// One axis cell: holds an axis of the table and adds its exponent term to the passing sum.
`default_nettype none
module gkfq_axis_cell
    import gkfq_pkg::*;
#(
    parameter int MAX_ENTRIES = GKFQ_MAX_ENTRIES,
    parameter int IDX_W = 8
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_we,
    input  wire [IDX_W-1:0]         i_waddr,
    input  wire signed [31:0]       i_wcenter,
    input  wire [31:0]              i_winv,
    input  wire signed [31:0]       i_pos,
    input  t_flow                   i_flow,
    input  wire [IDX_W-1:0]         i_idx,
    input  wire [SUM_W-1:0]         i_sum,
    output t_flow                   o_flow,
    output logic [IDX_W-1:0]        o_idx,
    output logic [SUM_W-1:0]        o_sum
);
    logic signed [31:0] r_mem_c  [MAX_ENTRIES];
    logic [31:0]        r_mem_iv [MAX_ENTRIES];

    t_flow r0_flow, r1_flow, r2_flow, r3_flow, r4_flow;
    logic [IDX_W-1:0] r0_idx, r1_idx, r2_idx, r3_idx, r4_idx;
    logic [SUM_W-1:0] r0_sum, r1_sum, r2_sum, r3_sum, r4_sum;
    logic signed [31:0] r0_c;
    logic [31:0] r0_iv, r1_iv, r2_iv;
    logic [32:0] r1_m;
    logic [65:0] r2_sq;
    logic [52:0] r3_phi;
    logic [63:0] r3_plo;
    logic r3_cap, r3_zero;

    logic signed [32:0] w_d;
    logic [53:0] w_t;
    logic [TERM_W-1:0] w_term;

    assign w_d = 33'(i_pos) - 33'(r0_c);
    assign w_t = 54'(r3_phi) + 54'(r3_plo[63:32]);

    always_comb begin
        if (r3_zero) begin
            w_term = '0;
        end else if (r3_cap || (w_t > 54'(TERM_CAP))) begin
            w_term = TERM_CAP;
        end else begin
            w_term = w_t[TERM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_c[i_waddr]  <= i_wcenter;
            r_mem_iv[i_waddr] <= i_winv;
        end
        r0_c  <= r_mem_c[i_idx];
        r0_iv <= r_mem_iv[i_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_flow <= '0;
            r1_flow <= '0;
            r2_flow <= '0;
            r3_flow <= '0;
            r4_flow <= '0;
        end else begin
            r0_flow <= i_flow;
            r1_flow <= r0_flow;
            r2_flow <= r1_flow;
            r3_flow <= r2_flow;
            r4_flow <= r3_flow;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_idx  <= i_idx;
        r0_sum  <= i_sum;
        r1_idx  <= r0_idx;
        r1_sum  <= r0_sum;
        r1_iv   <= r0_iv;
        r1_m    <= w_d[32] ? 33'(-w_d) : 33'(w_d);
        r2_idx  <= r1_idx;
        r2_sum  <= r1_sum;
        r2_iv   <= r1_iv;
        r2_sq   <= 66'(r1_m) * 66'(r1_m);
        r3_idx  <= r2_idx;
        r3_sum  <= r2_sum;
        r3_phi  <= 53'(r2_sq[52:32]) * 53'(r2_iv);
        r3_plo  <= 64'(r2_sq[31:0]) * 64'(r2_iv);
        r3_cap  <= r2_sq[64:53] != 12'd0;
        r3_zero <= r2_iv == 32'd0;
        r4_idx  <= r3_idx;
        r4_sum  <= r3_sum + SUM_W'(w_term);
    end

    assign o_flow = r4_flow;
    assign o_idx  = r4_idx;
    assign o_sum  = r4_sum;

endmodule
`default_nettype wire

// ===== src/gkfq_weight_acc.sv =====
// Weight unit: exponential lookup, opacity scaling and accumulation of the weighted sums.
`default_nettype none
module gkfq_weight_acc
    import gkfq_pkg::*;
#(
    parameter int MAX_ENTRIES = GKFQ_MAX_ENTRIES,
    parameter int IDX_W = 8,
    parameter int WS_W = 41,
    parameter int SS_W = 57
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_we,
    input  wire [IDX_W-1:0]         i_waddr,
    input  wire [15:0]              i_wopacity,
    input  wire signed [15:0]       i_wsignal,
    input  wire                     i_clear,
    input  t_flow                   i_flow,
    input  wire [IDX_W-1:0]         i_idx,
    input  wire [SUM_W-1:0]         i_sum,
    output logic                    o_done,
    output logic [WS_W-1:0]         o_wsum,
    output logic signed [SS_W-1:0]  o_ssum
);
    logic [15:0]        r_mem_op  [MAX_ENTRIES];
    logic signed [15:0] r_mem_sig [MAX_ENTRIES];

    t_flow r0_flow, r1_flow, r2_flow, r3_flow, r4_flow;
    logic [15:0] r0_op, r1_op, r2_op;
    logic signed [15:0] r0_sig, r1_sig, r2_sig, r3_sig;
    logic r0_sat, r1_sat;
    logic [5:0] r0_j;
    logic [13:0] r0_f;
    logic [32:0] r1_tj, r2_e;
    logic [46:0] r1_prod;
    logic [31:0] r3_w, r4_w;
    logic signed [48:0] r4_sp;
    logic r_done;
    logic [WS_W-1:0] r_wsum;
    logic signed [SS_W-1:0] r_ssum;

    logic [21:0] w_a;
    logic [48:0] w_opw;

    assign w_a   = i_sum[SUM_W-1:1];
    assign w_opw = 49'(r2_op) * 49'(r2_e);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_op[i_waddr]  <= i_wopacity;
            r_mem_sig[i_waddr] <= i_wsignal;
        end
        r0_op  <= r_mem_op[i_idx];
        r0_sig <= r_mem_sig[i_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_flow <= '0;
            r1_flow <= '0;
            r2_flow <= '0;
            r3_flow <= '0;
            r4_flow <= '0;
            r_done  <= 1'b0;
        end else begin
            r0_flow <= i_flow;
            r1_flow <= r0_flow;
            r2_flow <= r1_flow;
            r3_flow <= r2_flow;
            r4_flow <= r3_flow;
            r_done  <= r4_flow.valid & r4_flow.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_sat  <= w_a[21:20] != 2'd0;
        r0_j    <= w_a[19:14];
        r0_f    <= w_a[13:0];
        r1_sat  <= r0_sat;
        r1_op   <= r0_op;
        r1_sig  <= r0_sig;
        r1_tj   <= EXP_TAB[7'(r0_j)];
        r1_prod <= 47'(EXP_TAB[7'(r0_j)] - EXP_TAB[7'(r0_j) + 7'd1]) * 47'(r0_f);
        r2_op   <= r1_op;
        r2_sig  <= r1_sig;
        r2_e    <= r1_sat ? EXP_TAB[64] : (r1_tj - 33'(r1_prod[46:14]));
        r3_sig  <= r2_sig;
        r3_w    <= w_opw[47:16];
        r4_w    <= r3_w;
        r4_sp   <= 49'(r3_sig) * $signed({17'd0, r3_w});
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_wsum <= '0;
            r_ssum <= '0;
        end else if (r4_flow.valid) begin
            r_wsum <= r_wsum + WS_W'(r4_w);
            r_ssum <= r_ssum + SS_W'(r4_sp);
        end
    end

    assign o_done = r_done;
    assign o_wsum = r_wsum;
    assign o_ssum = r_ssum;

endmodule
`default_nettype wire

// ===== src/gaussian_kernel_field_query.sv =====
// Top level of the Gaussian kernel field query block.
// A query feeds its entries into the axis cell chain one per cycle, as many as the active
// entry count; with coverage, a 17-step serial divider then forms the mean. The next beat can
// be taken in the cycle after the result loads. A table write to an active entry holds off
// the input for three passes, one per axis, each a 37-step serial division. Reset is
// synchronous, active low, clears control and the active count, sets the no-signal level to 16'h8800.
`default_nettype none
`include "gaussian_kernel_field_query_assert.svh"
module gaussian_kernel_field_query
    import gkfq_pkg::*;
#(
    parameter int MAX_ENTRIES = GKFQ_MAX_ENTRIES
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, opacity, signal level
    input  wire [231:0]  s_axis_tdata,
    // req_type
    input  wire [0:0]    s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // strength_dbm
    output logic [15:0]  m_axis_tdata,
    // no_coverage
    output logic [0:0]   m_axis_tuser,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [2:0]    paddr,
    input  wire [31:0]   pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int WS_W  = 32 + CNT_W;
    localparam int SS_W  = 48 + CNT_W;

    t_state r_state, n_state;

    logic [8:0]  r_active;
    logic [15:0] r_no_sig;
    logic [31:0] r_pos [3];
    logic [31:0] r_scale [3];
    logic [IDX_W-1:0] r_widx;
    logic [1:0]  r_axis;
    logic [63:0] r_dd;
    logic [CNT_W-1:0] r_iss;
    logic r_neg;
    logic [SS_W-1:0] r_num;
    logic [15:0] r_res;
    logic r_nocov;
    logic r_out_valid;
    logic [15:0] r_out_data;
    logic r_out_flag;

    logic w_in_fire, w_is_query, w_idx_ok, w_cfg_wr, w_load_out;
    logic [CNT_W-1:0] w_count;
    logic w_issue_last, w_wdiv_start, w_fdiv_start, w_cell_we, w_weight_we, w_acc_clear;
    logic w_wdiv_done, w_fdiv_done, w_acc_done, w_covered;
    logic [WR_QUO_W-1:0] w_wquo;
    logic [RD_QUO_W-1:0] w_fquo, w_qneg;
    logic [31:0] w_inv;
    logic [WS_W-1:0] w_wsum;
    logic signed [SS_W-1:0] w_ssum;
    logic [SS_W-1:0] w_mag;

    t_flow w_flow [4];
    logic [IDX_W-1:0] w_idx [4];
    logic [SUM_W-1:0] w_sum [4];

    assign w_in_fire  = s_axis_tvalid & s_axis_tready;
    assign w_is_query = s_axis_tuser[0];
    assign w_count    = (32'(r_active) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                          : CNT_W'(r_active);
    assign w_idx_ok   = 32'(s_axis_tdata[7:0]) < 32'(w_count);
    assign w_cfg_wr   = psel & penable & pwrite & pready;
    assign w_covered  = w_wsum > WS_W'(WEIGHT_FLOOR);
    assign w_mag      = w_ssum[SS_W-1] ? SS_W'(-w_ssum) : SS_W'(w_ssum);
    assign w_inv      = (w_wquo[WR_QUO_W-1:32] != '0) ? 32'hFFFF_FFFF : w_wquo[31:0];
    assign w_qneg     = RD_QUO_W'(0) - w_fquo;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (w_is_query) begin
                        n_state = (w_count == '0) ? ST_Q_PREP : ST_Q_RUN;
                    end else if (w_idx_ok) begin
                        n_state = ST_W_SQ;
                    end
                end
            end
            ST_W_SQ:    n_state = ST_W_DEN;
            ST_W_DEN:   n_state = ST_W_START;
            ST_W_START: n_state = ST_W_WAIT;
            ST_W_WAIT: begin
                if (w_wdiv_done) begin
                    n_state = (r_axis == 2'd2) ? ST_IDLE : ST_W_SQ;
                end
            end
            ST_Q_RUN: begin
                if (w_issue_last) begin
                    n_state = ST_Q_DRAIN;
                end
            end
            ST_Q_DRAIN: begin
                if (w_acc_done) begin
                    n_state = ST_Q_PREP;
                end
            end
            ST_Q_PREP:  n_state = w_covered ? ST_Q_START : ST_Q_DONE;
            ST_Q_START: n_state = ST_Q_WAIT;
            ST_Q_WAIT: begin
                if (w_fdiv_done) begin
                    n_state = ST_Q_SIGN;
                end
            end
            ST_Q_SIGN:  n_state = ST_Q_DONE;
            ST_Q_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = r_state == ST_IDLE;
        w_issue_last  = (r_state == ST_Q_RUN) && (r_iss == w_count - CNT_W'(1));
        w_wdiv_start  = r_state == ST_W_START;
        w_fdiv_start  = r_state == ST_Q_START;
        w_cell_we     = (r_state == ST_W_WAIT) && w_wdiv_done;
        w_weight_we   = (r_state == ST_IDLE) && w_in_fire && !w_is_query && w_idx_ok;
        w_acc_clear   = (r_state == ST_IDLE) && w_in_fire && w_is_query;
        w_load_out    = (r_state == ST_Q_DONE) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 9'd0;
            r_no_sig    <= 16'h8800;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_ACTIVE_ENTRIES: r_active <= pwdata[8:0];
                    REG_NO_SIGNAL:      r_no_sig <= pwdata[15:0];
                    default:            r_active <= r_active;
                endcase
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_pos[0]   <= s_axis_tdata[39:8];
            r_pos[1]   <= s_axis_tdata[71:40];
            r_pos[2]   <= s_axis_tdata[103:72];
            r_scale[0] <= s_axis_tdata[135:104];
            r_scale[1] <= s_axis_tdata[167:136];
            r_scale[2] <= s_axis_tdata[199:168];
            r_widx     <= IDX_W'(s_axis_tdata[7:0]);
            r_axis     <= 2'd0;
            r_iss      <= '0;
        end
        if (r_state == ST_W_SQ) begin
            r_dd <= 64'(r_scale[r_axis]) * 64'(r_scale[r_axis]);
        end
        if (r_state == ST_W_DEN) begin
            r_dd <= r_dd + EPS_Q32;
        end
        if (w_cell_we) begin
            r_axis <= r_axis + 2'd1;
        end
        if (r_state == ST_Q_RUN) begin
            r_iss <= r_iss + CNT_W'(1);
        end
        if (r_state == ST_Q_PREP) begin
            r_neg   <= w_ssum[SS_W-1];
            r_num   <= w_mag + SS_W'(w_wsum >> 1);
            r_res   <= r_no_sig;
            r_nocov <= 1'b1;
        end
        if (r_state == ST_Q_SIGN) begin
            r_res   <= r_neg ? w_qneg[15:0] : w_fquo[15:0];
            r_nocov <= 1'b0;
        end
        if (w_load_out) begin
            r_out_data <= r_res;
            r_out_flag <= r_nocov;
        end
    end

    assign w_flow[0] = '{valid: r_state == ST_Q_RUN, last: w_issue_last};
    assign w_idx[0]  = IDX_W'(r_iss);
    assign w_sum[0]  = '0;

    for (genvar k = 0; k < 3; k++) begin : g_cell
        gkfq_axis_cell #(
            .MAX_ENTRIES(MAX_ENTRIES),
            .IDX_W(IDX_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_we     (w_cell_we && (r_axis == 2'(k))),
            .i_waddr  (r_widx),
            .i_wcenter(r_pos[k]),
            .i_winv   (w_inv),
            .i_pos    (r_pos[k]),
            .i_flow   (w_flow[k]),
            .i_idx    (w_idx[k]),
            .i_sum    (w_sum[k]),
            .o_flow   (w_flow[k+1]),
            .o_idx    (w_idx[k+1]),
            .o_sum    (w_sum[k+1])
        );
    end

    gkfq_weight_acc #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .IDX_W(IDX_W),
        .WS_W(WS_W),
        .SS_W(SS_W)
    ) u_weight (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_weight_we),
        .i_waddr   (IDX_W'(s_axis_tdata[7:0])),
        .i_wopacity(s_axis_tdata[215:200]),
        .i_wsignal (s_axis_tdata[231:216]),
        .i_clear   (w_acc_clear),
        .i_flow    (w_flow[3]),
        .i_idx     (w_idx[3]),
        .i_sum     (w_sum[3]),
        .o_done    (w_acc_done),
        .o_wsum    (w_wsum),
        .o_ssum    (w_ssum)
    );

    gkfq_serial_div #(
        .NUM_W(64),
        .DEN_W(64),
        .QUO_W(WR_QUO_W)
    ) u_wdiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_wdiv_start),
        .i_num  (ONE_Q48 + (r_dd >> 1)),
        .i_den  (r_dd),
        .o_done (w_wdiv_done),
        .o_quo  (w_wquo)
    );

    gkfq_serial_div #(
        .NUM_W(SS_W),
        .DEN_W(WS_W),
        .QUO_W(RD_QUO_W)
    ) u_fdiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_fdiv_start),
        .i_num  (r_num),
        .i_den  (w_wsum),
        .o_done (w_fdiv_done),
        .o_quo  (w_fquo)
    );

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_flag;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_NO_SIGNAL) ? {{16{r_no_sig[15]}}, r_no_sig}
                                                         : {23'd0, r_active};

    `GKFQ_ASSERT_IMP(a_wdiv_done_in_wait, w_wdiv_done, r_state == ST_W_WAIT)
    `GKFQ_ASSERT_IMP(a_fdiv_done_in_wait, w_fdiv_done, r_state == ST_Q_WAIT)
    `GKFQ_ASSERT_IMP(a_acc_done_in_drain, w_acc_done, r_state == ST_Q_DRAIN)
    `GKFQ_ASSERT_NXT(a_out_held, r_out_valid && !m_axis_tready,
                     r_out_valid && $stable(r_out_data) && $stable(r_out_flag))

endmodule
`default_nettype wire

// ===== dv/tb_gaussian_kernel_field_query.sv =====
// Self-checking testbench for the Gaussian kernel field query block.
`timescale 1ns / 1ps
module tb_gaussian_kernel_field_query;
    import gkfq_pkg::*;

    localparam logic [2:0] ADDR_ACTIVE = {REG_ACTIVE_ENTRIES, 2'b00};
    localparam logic [2:0] ADDR_NOSIG = {REG_NO_SIGNAL, 2'b00};
    localparam logic [63:0] AXIS_CAP = 64'd32 << 16;
    localparam logic [63:0] EXPO_LIMIT = 64'd16 << 16;
    localparam int TABLE_DEPTH = 256;

    typedef enum logic {REQ_WRITE = 1'b0, REQ_QUERY = 1'b1} t_req;

    typedef struct {
        t_req               req;
        logic [7:0]         idx;
        logic signed [31:0] pos [3];
        logic [31:0]        scl [3];
        logic [15:0]        opac;
        logic signed [15:0] sig;
    } t_item;

    typedef struct {
        logic [15:0] strength;
        logic        no_cov;
    } t_strength;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [231:0]  s_axis_tdata;
    logic [0:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [15:0]   m_axis_tdata;
    logic [0:0]    m_axis_tuser;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    gaussian_kernel_field_query u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor state: kernel table mirror and configuration.
    longint             kern_center [TABLE_DEPTH][3];
    logic [31:0]        kern_ivar [TABLE_DEPTH][3];
    logic [15:0]        kern_opac [TABLE_DEPTH];
    logic signed [15:0] kern_sig [TABLE_DEPTH];
    int unsigned        cfg_active;
    logic [15:0]        cfg_nosig;
    logic [63:0]        exp_q32 [0:64];
    bit                 slot_written [TABLE_DEPTH];

    t_item     pending_items[$];
    t_strength expected_strength[$];
    t_item     item_on_bus;
    logic      in_taken;
    logic      quiet_mode;
    int        hold_cycles;
    int        mismatches;
    int        n_queries;
    int        n_covered;
    int        n_writes;
    int        n_phases;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] inv_variance(logic [31:0] s);
        logic [63:0] d;
        logic [63:0] q;
        d = {32'd0, s} * {32'd0, s} + 64'd4295;
        q = ((64'd1 << 48) + d / 2) / d;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic logic [63:0] axis_cost(longint p, longint c, logic [31:0] iv);
        longint      d;
        logic [63:0] m;
        logic [63:0] sq;
        logic [63:0] t;
        d = p - c;
        m = (d < 0) ? -d : d;
        sq = m * m;
        if (iv == 0) return 64'd0;
        if ((sq >> 32) >= AXIS_CAP) return AXIS_CAP;
        t = (sq >> 32) * iv + ((sq[31:0] * {32'd0, iv}) >> 32);
        return (t > AXIS_CAP) ? AXIS_CAP : t;
    endfunction

    function automatic logic [63:0] exp_neg_q32(logic [63:0] a);
        logic [63:0] j;
        logic [63:0] f;
        if (a >= EXPO_LIMIT) return exp_q32[64];
        j = a >> 14;
        f = a & 64'h3FFF;
        return exp_q32[j] - (((exp_q32[j] - exp_q32[j + 1]) * f) >> 14);
    endfunction

    task automatic predict_strength(t_item it);
        int unsigned n;
        logic [63:0] wsum;
        longint      ssum;
        logic [63:0] sum;
        logic [63:0] w;
        logic [63:0] mag;
        longint      q;
        t_strength   r;
        n = (cfg_active > TABLE_DEPTH) ? TABLE_DEPTH : cfg_active;
        if (it.req == REQ_WRITE) begin
            n_writes++;
            if (it.idx < n) begin
                for (int ax = 0; ax < 3; ax++) begin
                    kern_center[it.idx][ax] = longint'(it.pos[ax]);
                    kern_ivar[it.idx][ax] = inv_variance(it.scl[ax]);
                end
                kern_opac[it.idx] = it.opac;
                kern_sig[it.idx] = it.sig;
            end
            return;
        end
        n_queries++;
        wsum = 0;
        ssum = 0;
        for (int i = 0; i < n; i++) begin
            sum = 0;
            for (int ax = 0; ax < 3; ax++)
                sum += axis_cost(longint'(it.pos[ax]), kern_center[i][ax], kern_ivar[i][ax]);
            sum = sum >> 1;
            if (sum > EXPO_LIMIT) sum = EXPO_LIMIT;
            w = ({48'd0, kern_opac[i]} * exp_neg_q32(sum)) >> 16;
            wsum += w;
            ssum += longint'(kern_sig[i]) * longint'(w);
        end
        if (wsum > 64'd4295) begin
            mag = (ssum < 0) ? -ssum : ssum;
            q = longint'((mag + wsum / 2) / wsum);
            if (ssum < 0) q = -q;
            r.strength = q[15:0];
            r.no_cov = 1'b0;
            n_covered++;
        end else begin
            r.strength = cfg_nosig;
            r.no_cov = 1'b1;
        end
        expected_strength = {expected_strength, r};
    endtask

    // Input side: accept at the rising edge, change at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_strength(item_on_bus);
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (pending_items.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 6)) begin
                item_on_bus = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= item_on_bus.req;
                s_axis_tdata <= {item_on_bus.sig, item_on_bus.opac,
                                 item_on_bus.scl[2], item_on_bus.scl[1], item_on_bus.scl[0],
                                 item_on_bus.pos[2], item_on_bus.pos[1], item_on_bus.pos[0],
                                 item_on_bus.idx};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet_mode || $urandom_range(0, 99) >= 6;
        end
    end

    always @(posedge i_clk) begin
        t_strength e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_strength.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: strength %h no_coverage %b",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                e = expected_strength.pop_front();
                if (e.strength !== m_axis_tdata || e.no_cov !== m_axis_tuser[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected strength %h no_coverage %b, got %h %b",
                                 e.strength, e.no_cov, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_ACTIVE) cfg_active = data[8:0];
        else cfg_nosig = data[15:0];
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_strength.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_item noise_item(t_req req);
        t_item it;
        it.req = req;
        it.idx = $urandom_range(0, 255);
        for (int ax = 0; ax < 3; ax++) begin
            it.pos[ax] = $urandom;
            it.scl[ax] = $urandom;
        end
        it.opac = $urandom;
        it.sig = $urandom;
        return it;
    endfunction

    function automatic t_item kernel_item(int idx);
        t_item it;
        it = noise_item(REQ_WRITE);
        it.idx = idx;
        for (int ax = 0; ax < 3; ax++) begin
            it.pos[ax] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            it.scl[ax] = $urandom_range(32'h4000, 32'h40000);
        end
        return it;
    endfunction

    function automatic t_item near_query(int n);
        t_item it;
        int    k;
        it = noise_item(REQ_QUERY);
        k = $urandom_range(0, n - 1);
        for (int ax = 0; ax < 3; ax++)
            it.pos[ax] = kern_center[k][ax] + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        return it;
    endfunction

    task automatic configure(int n, logic [15:0] nosig);
        wait_idle();
        reg_write(ADDR_ACTIVE, n);
        reg_write(ADDR_NOSIG, {16'd0, nosig});
        n_phases++;
        for (int i = 0; i < n; i++)
            if (!slot_written[i]) begin
                pending_items = {pending_items, kernel_item(i)};
                slot_written[i] = 1'b1;
            end
    endtask

    task automatic random_mix(int n_items, int n);
        int roll;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            if (n > 0 && roll < 55) pending_items = {pending_items, near_query(n)};
            else if (roll < 67 || n == 0)
                pending_items = {pending_items, noise_item(REQ_QUERY)};
            else if (roll < 90)
                pending_items = {pending_items, kernel_item($urandom_range(0, n - 1))};
            else pending_items = {pending_items, noise_item(REQ_WRITE)};
        end
    endtask

    initial begin
        t_item       it;
        int          counts [8];
        int          mixes [8];
        logic [15:0] levels [8];
        counts = '{16, 1, 256, 40, 8, 0, 100, 3};
        mixes = '{220, 150, 40, 240, 220, 60, 120, 180};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_taken = 1'b0;
        quiet_mode = 1'b0;
        hold_cycles = 0;
        mismatches = 0;
        cfg_active = 0;
        cfg_nosig = 16'h8800;
        exp_q32[0] = 64'h1_0000_0000;
        for (int k = 0; k < 64; k++)
            exp_q32[k + 1] = (exp_q32[k] * 64'd3344923893 + 64'h8000_0000) >> 32;
        for (int i = 0; i < TABLE_DEPTH; i++) slot_written[i] = 1'b0;
        levels = '{16'h7FFF, 16'h0000, $urandom, 16'h8000, $urandom, 16'h1234, $urandom,
                   16'hFFFF};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // With no active entries, writes are dropped and queries get the reset default.
        pending_items = {pending_items, noise_item(REQ_QUERY)};
        pending_items = {pending_items, noise_item(REQ_WRITE)};
        pending_items = {pending_items, noise_item(REQ_QUERY)};

        configure(4, 16'h8000);
        // Extreme kernels: zero spread, full spread, limits of opacity and level.
        it = kernel_item(0);
        it.scl = '{32'd0, 32'd0, 32'd0};
        it.opac = 16'hFFFF;
        it.sig = 16'h7FFF;
        pending_items = {pending_items, it};
        it = kernel_item(1);
        it.scl = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        it.pos = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        it.opac = 16'hFFFF;
        it.sig = 16'h8000;
        pending_items = {pending_items, it};
        it = kernel_item(2);
        it.opac = 16'h0000;
        pending_items = {pending_items, it};
        it = noise_item(REQ_WRITE);
        it.idx = 8'd255;
        pending_items = {pending_items, it};
        it = noise_item(REQ_QUERY);
        it.pos = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        pending_items = {pending_items, it};
        it = noise_item(REQ_QUERY);
        it.pos = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        pending_items = {pending_items, it};
        it = noise_item(REQ_QUERY);
        it.pos = '{32'd0, 32'd0, 32'd0};
        pending_items = {pending_items, it};
        for (int k = 0; k < 6; k++) pending_items = {pending_items, near_query(4)};
        for (int k = 0; k < 6; k++) pending_items = {pending_items, noise_item(REQ_QUERY)};

        for (int p = 0; p < 8; p++) begin
            configure(counts[p], levels[p]);
            quiet_mode = (p == 4);
            if (p == 3) hold_cycles = 4000;
            random_mix(mixes[p], counts[p]);
        end
        wait_idle();
        quiet_mode = 1'b0;

        $display("Covered %0d config phases, %0d table writes and %0d queries, %0d with coverage.",
                 n_phases, n_writes, n_queries, n_covered);
        $display("Mismatches seen: %0d.", mismatches);
        if (mismatches == 0 && expected_strength.size() == 0) begin
            $display("gaussian_kernel_field_query regression: pass");
        end else begin
            $display("gaussian_kernel_field_query regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("gaussian_kernel_field_query regression: fail");
        $finish;
    end

endmodule
